@@ hdl/plfse_pkg.sv @@
// Shared types and constants for the parallel LED four-step encoder.
// No dependencies; every other file in hdl/ imports this package.
package plfse_pkg;

  localparam int unsigned Lanes        = 16;
  localparam int unsigned Planes       = 8;
  localparam int unsigned StepW        = 16;
  localparam int unsigned WordsPerSlot = 2 * Planes;
  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned QPtrW        = $clog2(QueueDepth);
  localparam int unsigned QCntW        = QPtrW + 1;
  localparam int unsigned IdxW         = $clog2(WordsPerSlot);
  localparam int unsigned PlaneIdxW    = $clog2(Planes);
  localparam int unsigned ChanW        = 4;
  localparam int unsigned AddrW        = 3;

  localparam logic ModeAdd    = 1'b0;
  localparam logic ModeClose  = 1'b1;
  localparam logic RegSwapIdx = 1'b0;
  localparam logic SwapReset  = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [ChanW-1:0] channel;
    logic [7:0]       data_byte;
  } in_word_t;

  typedef struct packed {
    logic [31:0] dma_word;
    logic        last_word;
    logic        frame_done;
  } out_word_t;

  // One closed slot: plane i holds bit (7 - i) of every lane.
  typedef struct packed {
    logic [Planes-1:0][StepW-1:0] planes;
    logic [StepW-1:0]             mask;
  } slot_t;

endpackage

@@ hdl/plfse_gather.sv @@
// Front end: gathers lane bytes into bit planes and the active mask,
// and hands a finished slot to the queue on a close word. Uses plfse_pkg.
module plfse_gather (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  plfse_pkg::in_word_t in_data_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output plfse_pkg::slot_t   q_slot_o
);
  import plfse_pkg::*;

  logic [Planes-1:0][StepW-1:0] planes_q, planes_d;
  logic [StepW-1:0]             mask_q, mask_d;
  logic [StepW-1:0]             lane_bit;
  logic                         lane_ok;
  logic                         accept;

  // a close needs a free queue slot; adds never wait
  assign in_stall_o = (in_data_i.mode == ModeClose) && q_full_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign lane_ok  = (5'(in_data_i.channel) < 5'(Lanes));
  assign lane_bit = StepW'(1) << in_data_i.channel;

  assign q_push_o        = accept && (in_data_i.mode == ModeClose);
  assign q_slot_o.planes = planes_q;
  assign q_slot_o.mask   = mask_q;

  always_comb begin
    planes_d = planes_q;
    mask_d   = mask_q;
    if (accept) begin
      if (in_data_i.mode == ModeClose) begin
        planes_d = '0;
        mask_d   = '0;
      end else if (lane_ok) begin
        mask_d = mask_q | lane_bit;
        for (int i = 0; i < Planes; i++) begin
          if (in_data_i.data_byte[Planes-1-i]) begin
            planes_d[i] = planes_q[i] | lane_bit;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      planes_q <= '0;
      mask_q   <= '0;
    end else begin
      planes_q <= planes_d;
      mask_q   <= mask_d;
    end
  end

endmodule

@@ hdl/plfse_queue.sv @@
// Short slot queue between the gather front end and the word emitter.
// Uses plfse_pkg for the slot type and depth.
module plfse_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  plfse_pkg::slot_t slot_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output plfse_pkg::slot_t head_o
);
  import plfse_pkg::*;

  slot_t            mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_q <= QPtrW'((32'(wr_q) + 1) % QueueDepth);
      end
      if (do_pop) begin
        rd_q <= QPtrW'((32'(rd_q) + 1) % QueueDepth);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= slot_i;
    end
  end

endmodule

@@ hdl/plfse_emit.sv @@
// Back end: walks the queue head slot and emits its sixteen line-code
// words (or one end-of-frame word) through an output register. Uses plfse_pkg.
module plfse_emit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 swap_i,
  input  logic                 head_valid_i,
  input  plfse_pkg::slot_t     head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output plfse_pkg::out_word_t out_data_o
);
  import plfse_pkg::*;

  logic [IdxW-1:0]  idx_q, idx_d;
  logic             out_valid_q, out_valid_d;
  out_word_t        out_q, word_d;
  logic             advance;
  logic             empty_slot;
  logic             final_word;
  logic [StepW-1:0] plane;

  assign advance    = head_valid_i && (!out_valid_q || !out_stall_i);
  assign empty_slot = (head_i.mask == '0);
  assign final_word = (idx_q == IdxW'(WordsPerSlot - 1));
  assign plane      = head_i.planes[idx_q[IdxW-1:1]];
  assign pop_o      = advance && (empty_slot || final_word);

  // even index: high step + first data step; odd: second data step + low step
  always_comb begin
    word_d = '0;
    if (empty_slot) begin
      word_d.last_word  = 1'b1;
      word_d.frame_done = 1'b1;
    end else begin
      word_d.last_word = final_word;
      if (!idx_q[0]) begin
        word_d.dma_word = swap_i ? {head_i.mask, plane} : {plane, head_i.mask};
      end else begin
        word_d.dma_word = swap_i ? {plane, StepW'(0)} : {StepW'(0), plane};
      end
    end
  end

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
      if (!empty_slot) begin
        idx_d = final_word ? '0 : idx_q + 1'b1;
      end
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ hdl/parallel_led_four_step_encoder_core.sv @@
// Top level of the parallel LED four-step encoder: APB register, gather
// front end, slot queue and word emitter. Uses plfse_pkg and all plfse_* modules.

// Add words are taken one per cycle and never stall. A close word copies the
// gathered slot into a two-entry queue and stalls only while that queue is
// full. The emitter drains the queue head at one output word per cycle while
// the output is not stalled: sixteen words for a slot with active lanes and
// one for an empty close, so a stream of slots with active lanes is paced by
// the emitter. The half-word swap register resets to 1, sampled as words leave.
module parallel_led_four_step_encoder_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  plfse_pkg::in_word_t          in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output plfse_pkg::out_word_t         out_data_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [plfse_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import plfse_pkg::*;

  logic  swap_q;
  logic  cfg_wr;
  logic  q_full, q_push, q_pop, q_valid;
  slot_t q_slot, q_head;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == RegSwapIdx);
  assign prdata = (paddr[2] == RegSwapIdx) ? {31'b0, swap_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swap_q <= SwapReset;
    end else if (cfg_wr) begin
      swap_q <= pwdata[0];
    end
  end

  plfse_gather u_gather (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_slot_o   (q_slot)
  );

  plfse_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .slot_i  (q_slot),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  plfse_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .swap_i       (swap_q),
    .head_valid_i (q_valid),
    .head_i       (q_head),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

`ifndef NO_ASSERTIONS
  a_done_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_done |->
      out_data_o.last_word && (out_data_o.dma_word == 32'b0))
    else $error("end-of-frame word must be a zero last word");

  a_stall_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_data_i.mode == ModeClose) && q_full)
    else $error("front end stalled without a blocked close");

  a_full_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> q_valid)
    else $error("queue full but no head slot");

  a_pop_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> out_valid_o && out_data_o.last_word)
    else $error("slot retired without its last word");
`endif

endmodule

@@ bench/plfse_word_checker.sv @@
// Checker for the parallel LED four-step encoder: watches the input, output and
// register ports, predicts every output word and compares it. Uses plfse_pkg.
module plfse_word_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  plfse_pkg::in_word_t  in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  plfse_pkg::out_word_t out_data_i,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  input  logic [31:0]          prdata,
  input  logic                 pready,
  output int unsigned          pending_o,
  output int unsigned          errors_o
);
  import plfse_pkg::*;

  localparam logic [2:0] SwapAddr = 3'(4 * RegSwapIdx);

  logic [StepW-1:0] planes_q [Planes];
  logic [StepW-1:0] lanes_q;
  logic             swap_q;
  out_word_t        pending_words [$];

  initial begin
    pending_o = 0;
    errors_o  = 0;
  end

  function automatic out_word_t make_word(logic [31:0] w, logic last, logic done);
    out_word_t o;
    o.dma_word   = w;
    o.last_word  = last;
    o.frame_done = done;
    return o;
  endfunction

  task automatic clear_slot();
    for (int i = 0; i < Planes; i++) planes_q[i] = '0;
    lanes_q = '0;
  endtask

  // add word: OR the byte into the planes, MSB into plane 0
  task automatic gather_byte(in_word_t w);
    logic [StepW-1:0] m;
    if (w.channel < Lanes) begin
      m = StepW'(1) << w.channel;
      lanes_q = lanes_q | m;
      for (int i = 0; i < Planes; i++)
        if (w.data_byte[7-i]) planes_q[i] = planes_q[i] | m;
    end
  endtask

  // close word: high step = lane mask, two data steps, low step = zero; an empty slot gives one end-of-frame word
  task automatic close_slot();
    logic [31:0] wa, wb;
    if (lanes_q == '0) begin
      pending_words.push_back(make_word('0, 1'b1, 1'b1));
    end else begin
      for (int i = 0; i < Planes; i++) begin
        if (swap_q) begin
          wa = {lanes_q, planes_q[i]};
          wb = {planes_q[i], 16'h0000};
        end else begin
          wa = {planes_q[i], lanes_q};
          wb = {16'h0000, planes_q[i]};
        end
        pending_words.push_back(make_word(wa, 1'b0, 1'b0));
        pending_words.push_back(make_word(wb, i == Planes - 1, 1'b0));
      end
    end
    clear_slot();
  endtask

  task automatic check_word(out_word_t got);
    out_word_t want;
    if (pending_words.size() == 0) begin
      $error("unexpected word %h", got);
      errors_o++;
    end else begin
      want = pending_words.pop_front();
      if (got.dma_word !== want.dma_word) begin
        $error("dma_word expected %h actual %h", want.dma_word, got.dma_word);
        errors_o++;
      end
      if (got.last_word !== want.last_word) begin
        $error("last_word expected %0d actual %0d", want.last_word, got.last_word);
        errors_o++;
      end
      if (got.frame_done !== want.frame_done) begin
        $error("frame_done expected %0d actual %0d", want.frame_done, got.frame_done);
        errors_o++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      clear_slot();
      swap_q = SwapReset;
      pending_words.delete();
    end else begin
      // register access phase
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == SwapAddr) swap_q = pwdata[0];
        end else if (paddr == SwapAddr && prdata !== {31'b0, swap_q}) begin
          $error("swap_half_words expected %h actual %h", {31'b0, swap_q}, prdata);
          errors_o++;
        end
      end
      if (out_valid_i && !out_stall_i) check_word(out_data_i);
      if (in_valid_i && !in_stall_i) begin
        if (in_data_i.mode == ModeClose) close_slot();
        else gather_byte(in_data_i);
      end
    end
    pending_o <= pending_words.size();
  end

endmodule

@@ bench/tb_parallel_led_four_step_encoder_core.sv @@
// Testbench top for parallel_led_four_step_encoder_core: clock, reset, word and
// register stimulus, verdict. Needs plfse_pkg, plfse_word_checker and the encoder core.
module tb_parallel_led_four_step_encoder_core;
  import plfse_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 8;
  localparam logic [2:0]  SwapAddr  = 3'(4 * RegSwapIdx);
  localparam logic [2:0]  SpareAddr = 3'd4;  // no register here

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_word_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_word_t   out_data_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  int unsigned pending;
  int unsigned errors;
  int unsigned cycles = 0;
  int unsigned words_sent = 0;
  bit          quiet = 1'b0;  // no gaps, no stalls
  int unsigned stall_left = 0;
  int unsigned out_wait;

  parallel_led_four_step_encoder_core u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  plfse_word_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .pending_o(pending), .errors_o(errors)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // output side: a random stall after each word, random while idle
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= (stall_left != 1);
    end else if (out_valid_o && !out_stall_i) begin
      out_wait     = quiet ? 0 : $urandom_range(0, 3);
      stall_left  <= out_wait;
      out_stall_i <= (out_wait != 0);
    end else begin
      out_stall_i <= quiet ? 1'b0 : 1'($urandom_range(0, 1));
    end
  end

  function automatic in_word_t add_word(logic [ChanW-1:0] ch, logic [7:0] b);
    in_word_t w;
    w.mode      = ModeAdd;
    w.channel   = ch;
    w.data_byte = b;
    return w;
  endfunction

  function automatic in_word_t close_word();
    in_word_t w;
    w.mode      = ModeClose;
    w.channel   = ChanW'($urandom);  // ignored on a close
    w.data_byte = 8'($urandom);
    return w;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_word(in_word_t w);
    int unsigned gap;
    logic [$bits(in_word_t)-1:0] junk;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      junk = $bits(in_word_t)'($urandom);
      in_valid_i <= 1'b0;
      in_data_i  <= junk;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
  endtask

  task automatic reg_access(logic wr, logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // wait until every predicted word has left, then let the pipe settle
  task automatic drain();
    in_valid_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic send_slot();
    int unsigned kind;
    int unsigned n;
    logic [$bits(in_word_t)-1:0] noise;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      send_word(close_word());
    end else if (kind == 1) begin
      for (int ch = 0; ch < Lanes; ch++) send_word(add_word(ChanW'(ch), pick_byte()));
      send_word(close_word());
    end else if (kind == 2) begin
      noise = $bits(in_word_t)'($urandom);
      send_word(noise);
    end else begin
      n = $urandom_range(1, 6);
      repeat (n) send_word(add_word(ChanW'($urandom_range(0, 15)), pick_byte()));
      send_word(close_word());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset value of the swap, empty closes, lane extremes, OR of a
    // lane written twice
    reg_access(1'b0, SwapAddr, '0);
    send_word(close_word());
    send_word(add_word(4'd0, 8'hFF));
    send_word(add_word(4'd15, 8'h00));
    send_word(close_word());
    send_word(add_word(4'd15, 8'h80));
    send_word(add_word(4'd15, 8'h01));
    send_word(add_word(4'd7, 8'hAA));
    send_word(close_word());
    send_word(close_word());
    drain();
    reg_access(1'b1, SwapAddr, 32'hFFFF_FFFE);  // upper bits ignored
    reg_access(1'b0, SwapAddr, '0);
    send_word(add_word(4'd0, 8'h55));
    send_word(add_word(4'd8, 8'hFF));
    send_word(add_word(4'd15, 8'h01));
    send_word(close_word());
    send_word(close_word());
    drain();

    // random phases through both swap settings, one phase without idling
    for (int phase = 0; phase < 4; phase++) begin
      reg_access(1'b1, SwapAddr, {31'($urandom), 1'(phase % 2)});
      if (phase == 1) reg_access(1'b1, SpareAddr, $urandom);
      reg_access(1'b0, SwapAddr, '0);
      quiet = (phase == 2);
      while (words_sent < 17 + 70 * (phase + 1)) send_slot();
      drain();
    end
    quiet = 1'b0;

    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/plfse_pkg.sv
hdl/plfse_gather.sv
hdl/plfse_queue.sv
hdl/plfse_emit.sv
hdl/parallel_led_four_step_encoder_core.sv
bench/plfse_word_checker.sv
bench/tb_parallel_led_four_step_encoder_core.sv
